// ===== hw/rtl/plwm_pkg.sv =====
// ----------------------------------------------------------------------------
// plwm_pkg
// shared widths, codes and handshake structs of the warp map core
// ----------------------------------------------------------------------------
package plwm_pkg;

	// table geometry, power of two
	localparam int MAX_MARKERS = 64;
	localparam int ADDR_W      = $clog2(MAX_MARKERS);
	localparam int FRAC        = 8;

	// field widths
	localparam int OPC_W   = 2;
	localparam int IDX_W   = 6;
	localparam int COORD_W = 32;
	localparam int POS_W   = 41;
	localparam int SEG_W   = 6;
	localparam int CNT_W   = 7;
	localparam int ENTRY_W = 2 * COORD_W;

	// datapath widths
	localparam int BASE_W = COORD_W + FRAC;
	localparam int DIFF_W = ((POS_W > BASE_W) ? POS_W : BASE_W) + 1;
	localparam int HI_W   = DIFF_W - COORD_W;
	localparam int PROD_W = DIFF_W + COORD_W;
	localparam int DIV_W  = PROD_W + (PROD_W % 2);
	localparam int Q_W    = 48;
	localparam int QR_W   = Q_W + 1;
	localparam int SUM_W  = ((QR_W > BASE_W) ? QR_W : BASE_W) + 2;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MARKER_COUNT = 1'b0;

	typedef enum logic [OPC_W-1:0] {
		OP_WRITE = 2'd0,
		OP_FWD   = 2'd1,
		OP_INV   = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   dividend;
		logic [COORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_W-1:0]   quotient;
		logic [COORD_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== hw/rtl/plwm_in_if.sv =====
// ----------------------------------------------------------------------------
// plwm_in_if
// request channel: marker writes and position queries
// ----------------------------------------------------------------------------
interface plwm_in_if
	import plwm_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic [IDX_W-1:0]        marker_index;
	logic [COORD_W-1:0]      marker_source;
	logic [COORD_W-1:0]      marker_dest;
	logic signed [POS_W-1:0] position;

	modport source (output valid, opcode, marker_index, marker_source, marker_dest, position,
		input ready);
	modport sink (input valid, opcode, marker_index, marker_source, marker_dest, position,
		output ready);
endinterface

// ===== hw/rtl/plwm_out_if.sv =====
// ----------------------------------------------------------------------------
// plwm_out_if
// result channel: mapped position and segment
// ----------------------------------------------------------------------------
interface plwm_out_if
	import plwm_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] mapped_position;
	logic [SEG_W-1:0]        segment;

	modport source (output valid, mapped_position, segment, input ready);
	modport sink (input valid, mapped_position, segment, output ready);
endinterface

// ===== hw/rtl/plwm_ram.sv =====
// ----------------------------------------------------------------------------
// plwm_ram
// simple dual port ram, registered read
// ----------------------------------------------------------------------------
module plwm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/plwm_div.sv =====
// ----------------------------------------------------------------------------
// plwm_div
// restoring unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module plwm_div
	import plwm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int STEPS = DIV_W / 2;
	localparam int CYC_W = $clog2(STEPS + 1);

	logic [DIV_W-1:0]   dvd_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] den_q;
	logic [CYC_W-1:0]   cyc_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_W-1:0]   dvd_d;
	logic [COORD_W-1:0] rem_d;
	logic [COORD_W:0]   trial;

	// two dependent shift-subtract steps
	always_comb begin
		dvd_d = dvd_q;
		rem_d = rem_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_d, dvd_d[DIV_W-1]};
			dvd_d = {dvd_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				dvd_d[0] = 1'b1;
			end
			rem_d = trial[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cyc_q  <= CYC_W'(STEPS);
			end else if (busy_q) begin
				cyc_q <= cyc_q - 1'b1;
				if (cyc_q == CYC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;
endmodule

// ===== hw/rtl/piecewise_linear_warp_map_core.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_warp_map_core
// marker table lookup with linear interpolation between warp markers
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                               handshake
//  req       in    opcode, marker_index, marker_source, marker_dest,
//                  position                                              valid/ready
//  rsp       out   mapped_position, segment                              valid/ready
//  apb       in    marker_count at byte address 0                        psel/penable
//
//  a write or pass-through transaction goes through ST_FIN to the output register
//  a query goes through ST_SCAN, ST_RD0, ST_RD1, ST_PREP, ST_MUL0, ST_MUL1, ST_DIV
//  and ST_FIN, a flat segment straight from ST_PREP to ST_FIN; the scan reads one
//  table entry a cycle from the single read port, the divider two quotient bits a cycle
//  reset clears control state and marker_count; table contents stay undefined
//  a new request is taken while a finished result waits on rsp; a stalled rsp
//  holds the core in its final state until the output register frees up
//
module piecewise_linear_warp_map_core
	import plwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	plwm_in_if.sink              req,
	plwm_out_if.source           rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SCAN = 9'b000000010,
		ST_RD0  = 9'b000000100,
		ST_RD1  = 9'b000001000,
		ST_PREP = 9'b000010000,
		ST_MUL0 = 9'b000100000,
		ST_MUL1 = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	// saturation bounds of the output format, at sum width
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'd1 << (POS_W - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
	localparam logic signed [POS_W-1:0] OUT_MAX = SUM_MAX[POS_W-1:0];
	localparam logic signed [POS_W-1:0] OUT_MIN = SUM_MIN[POS_W-1:0];

	state_t state_q;

	// configuration
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] m_eff;

	// query context
	logic signed [POS_W-1:0] pos_q;
	logic                    fwd_q;
	logic [ADDR_W-1:0]       m2_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [COORD_W-1:0]      key0_q, val0_q, key1_q, val1_q;

	// arithmetic
	logic [DIFF_W-1:0]  dm_q;
	logic [COORD_W-1:0] db_q;
	logic [COORD_W-1:0] den_q;
	logic               neg_q;
	logic [BASE_W-1:0]  base_q;
	logic [PROD_W-1:0]  prod_q;
	logic               start_q;
	logic [QR_W-1:0]    qr_q;
	logic               ovf_q;
	logic               sum_q;

	// result and output registers
	logic signed [POS_W-1:0] res_pos_q;
	logic [SEG_W-1:0]        res_seg_q;
	logic signed [POS_W-1:0] out_pos_q;
	logic [SEG_W-1:0]        out_seg_q;
	logic                    out_valid_q;

	// memory
	logic                we;
	logic [ADDR_W-1:0]   raddr;
	logic [ENTRY_W-1:0]  rdata;
	logic [COORD_W-1:0]  rd_key, rd_val;

	// combinational helpers
	logic                     accept;
	logic                     fin_load;
	logic signed [DIFF_W-1:0] pos_ext, key_ext, diff;
	logic                     hit;
	logic                     flat;
	logic [2*COORD_W-1:0]     prod_lo;
	logic [HI_W+COORD_W-1:0]  prod_hi;
	logic                     rnd;
	logic signed [SUM_W-1:0]  sq, sum;
	logic signed [POS_W-1:0]  sum_sat;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// ------------------------------------------------------------------------
	// apb register file: marker_count only
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_MARKER_COUNT) ? PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[PADDR_W-1:2] == REG_MARKER_COUNT) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	// counts past the table depth clamp to it
	assign m_eff = (count_q > CNT_W'(MAX_MARKERS)) ? CNT_W'(MAX_MARKERS) : count_q;

	// ------------------------------------------------------------------------
	// marker table
	// ------------------------------------------------------------------------
	assign accept = req.valid && req.ready;
	assign we     = accept && (req.opcode == OP_WRITE);

	// scan reads key[idx+1]; on a hit, fetch the segment's two markers
	always_comb begin
		case (state_q)
			ST_IDLE: raddr = ADDR_W'(1);
			ST_SCAN: raddr = hit ? idx_q : idx_q + ADDR_W'(2);
			ST_RD0:  raddr = idx_q + ADDR_W'(1);
			default: raddr = idx_q;
		endcase
	end

	plwm_ram #(
		.DEPTH (MAX_MARKERS),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (ADDR_W'(req.marker_index)),
		.wdata ({req.marker_dest, req.marker_source}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// source in the low half, timeline in the high half
	assign rd_key = fwd_q ? rdata[COORD_W-1:0] : rdata[ENTRY_W-1:COORD_W];
	assign rd_val = fwd_q ? rdata[ENTRY_W-1:COORD_W] : rdata[COORD_W-1:0];

	// ------------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------------
	assign pos_ext = DIFF_W'(pos_q);
	assign key_ext = $signed(DIFF_W'(rd_key) << FRAC);
	// first segment whose upper key reaches the position, else the last one
	assign hit     = (pos_ext <= key_ext) || (idx_q == m2_q);

	assign diff = pos_ext - $signed(DIFF_W'(key0_q) << FRAC);
	assign flat = key1_q <= key0_q;

	assign prod_lo = dm_q[COORD_W-1:0] * db_q;
	assign prod_hi = dm_q[DIFF_W-1:COORD_W] * db_q;

	// round half away from zero on the magnitude
	assign rnd = {div_rsp.remainder, 1'b0} >= {1'b0, den_q};

	assign sq  = neg_q ? -$signed(SUM_W'(qr_q)) : $signed(SUM_W'(qr_q));
	assign sum = $signed(SUM_W'(base_q)) + sq;

	always_comb begin
		if (ovf_q) begin
			sum_sat = neg_q ? OUT_MIN : OUT_MAX;
		end else if (sum > SUM_MAX) begin
			sum_sat = OUT_MAX;
		end else if (sum < SUM_MIN) begin
			sum_sat = OUT_MIN;
		end else begin
			sum_sat = sum[POS_W-1:0];
		end
	end

	assign div_req.start    = start_q;
	assign div_req.dividend = DIV_W'(prod_q);
	assign div_req.divisor  = den_q;

	plwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.opcode inside {OP_FWD, OP_INV} && m_eff >= CNT_W'(2)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: if (hit) state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_PREP;
				ST_PREP: state_q <= flat ? ST_FIN : ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: begin
					state_q <= ST_DIV;
					start_q <= 1'b1;
				end
				ST_DIV:  if (sum_q) state_q <= ST_FIN;
				ST_FIN:  if (fin_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_q     <= req.position;
				fwd_q     <= (req.opcode == OP_FWD);
				m2_q      <= ADDR_W'(m_eff - CNT_W'(2));
				idx_q     <= '0;
				res_seg_q <= '0;
				res_pos_q <= (req.opcode inside {OP_FWD, OP_INV}) ? req.position : '0;
				sum_q     <= 1'b0;
			end
			ST_SCAN: if (!hit) idx_q <= idx_q + ADDR_W'(1);
			ST_RD0: begin
				key0_q <= rd_key;
				val0_q <= rd_val;
			end
			ST_RD1: begin
				key1_q <= rd_key;
				val1_q <= rd_val;
			end
			ST_PREP: begin
				// magnitudes and sign of the slope product
				dm_q      <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
				db_q      <= (val1_q >= val0_q) ? val1_q - val0_q : val0_q - val1_q;
				neg_q     <= diff[DIFF_W-1] ^ (val1_q < val0_q);
				den_q     <= key1_q - key0_q;
				base_q    <= BASE_W'(val0_q) << FRAC;
				res_seg_q <= SEG_W'(idx_q);
				// zero-width or descending segment gives its start value
				res_pos_q <= $signed(POS_W'(BASE_W'(val0_q) << FRAC));
			end
			ST_MUL0: prod_q <= PROD_W'(prod_lo);
			ST_MUL1: prod_q <= prod_q + (PROD_W'(prod_hi) << COORD_W);
			ST_DIV: begin
				if (div_rsp.done) begin
					ovf_q <= |div_rsp.quotient[DIV_W-1:Q_W];
					qr_q  <= QR_W'(div_rsp.quotient[Q_W-1:0]) + QR_W'(rnd);
					sum_q <= 1'b1;
				end
				if (sum_q) begin
					res_pos_q <= sum_sat;
				end
			end
			default: ;
		endcase
		if (fin_load) begin
			out_pos_q <= res_pos_q;
			out_seg_q <= res_seg_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.mapped_position = out_pos_q;
	assign rsp.segment         = out_seg_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= m2_q)
		else $error("scan ran past the last segment");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_flat_skip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PREP && flat |=> state_q == ST_FIN)
		else $error("flat segment did not bypass the divider");

endmodule
